@@ design/lds_pkg.sv @@
// Shared types, codes and an arithmetic helper of the LED dimmer with slew-rate ramp.
`default_nettype none
package lds_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_BUMP   = 3'd2,
    OP_ON     = 3'd3,
    OP_OFF    = 3'd4,
    OP_LOAD   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    REG_RAMP_STEP     = 2'd0,
    REG_INTERVAL      = 2'd1,
    REG_ACTIVE_CHANS  = 2'd2
  } reg_index_t;

  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned ACTIVE_W   = 3;
  localparam int unsigned PROD_W     = 2 * VALUE_W;
  localparam int unsigned QUOT_W     = 10;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
  localparam logic [VALUE_W-1:0] PERCENT_MAX = 8'd100;
  localparam logic [VALUE_W-1:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic ramp;
    logic adopt;
  } lane_ctl_t;

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_adv_t;

  function automatic logic [VALUE_W-1:0] approach(input logic [VALUE_W-1:0] cur,
                                                 input logic [VALUE_W-1:0] goal,
                                                 input logic [VALUE_W-1:0] step);
    logic [VALUE_W-1:0] room;
    logic [VALUE_W-1:0] move;
    begin
      room = (cur < goal) ? (goal - cur) : (cur - goal);
      move = (step < room) ? step : room;
      approach = (cur < goal) ? (cur + move) : (cur - move);
    end
  endfunction

endpackage
`default_nettype wire

@@ design/led_dimmer_slew_ramp.sv @@
// Top level of the multi-channel LED dimmer with slew-rate ramping.
//
// The slave stream carries one command per transfer; each command yields
// exactly one result transfer on the master stream with the duties of
// channels 0 to 3, the on flag and the ramping flag. Commands update the
// brightness and colour state in the cycle they are accepted; the result
// then passes a capture stage, a product stage and a divide-by-one-hundred
// stage that ends in the merging output register, one colour lane and one
// duty lane per channel working side by side.
// Throughput is one command per cycle while the receiver does not stall.
// When the receiver stalls, the three stages fill and s_tready falls only
// once all of them hold results; earlier stages keep accepting meanwhile.
// Synchronous reset clears the state, the pipeline and the registers to
// ramp_step 1, interval_ticks 10 and active_channels 4.
// Configuration is written through cfg_wen, cfg_addr and cfg_wdata; the user must write it only while idle, unenforced.
`default_nettype none
module led_dimmer_slew_ramp #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op[2:0], value[10:3], color_a[18:11], color_b[26:19], color_c[34:27],
  // color_d[42:35], color_count[45:43], zero[47:46]
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // duty_a[7:0], duty_b[15:8], duty_c[23:16], duty_d[31:24], lamp_on[32],
  // ramping[33], zero[39:34]
  output logic [39:0]      m_tdata,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned VW = lds_pkg::VALUE_W;
  localparam int unsigned IDX_W = 5;

  logic [VW-1:0]                 ramp_step;
  logic [lds_pkg::TICK_W-1:0]    interval_ticks;
  logic [lds_pkg::ACTIVE_W-1:0]  active_channels;

  logic [VW-1:0]                 bright_level;
  logic [VW-1:0]                 bright_target;
  logic                          switched_on;
  logic [lds_pkg::TICK_W-1:0]    tick_count;
  logic [VW-1:0]                 level_next;
  logic [VW-1:0]                 target_next;
  logic                          on_next;
  logic [lds_pkg::TICK_W-1:0]    tick_next;

  logic [2:0]                    in_op;
  logic [VW-1:0]                 in_value;
  logic [VW-1:0]                 in_color [4];
  logic [2:0]                    in_color_count;

  logic                          accept;
  logic [VW-1:0]                 step;
  logic [lds_pkg::TICK_W-1:0]    tick_inc;
  logic                          fire;
  logic [VW:0]                   bump_sum;
  lds_pkg::lane_ctl_t            lane_ctl;
  lds_pkg::pipe_adv_t            adv;
  logic                          moving_next;

  logic [CHANNELS-1:0]           lane_diff;
  logic [VW-1:0]                 lane_duty [CHANNELS];
  logic [VW-1:0]                 duty_out [4];

  logic                          valid1;
  logic                          valid2;
  logic                          ready1;
  logic                          ready2;
  logic                          ready3;
  logic [VW-1:0]                 level1;
  logic                          on1;
  logic                          moving1;
  logic                          on2;
  logic                          moving2;
  logic                          lamp_on;
  logic                          ramping;

  assign in_op          = s_tdata[2:0];
  assign in_value       = s_tdata[10:3];
  assign in_color[0]    = s_tdata[18:11];
  assign in_color[1]    = s_tdata[26:19];
  assign in_color[2]    = s_tdata[34:27];
  assign in_color[3]    = s_tdata[42:35];
  assign in_color_count = s_tdata[45:43];

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step       <= 8'd1;
      interval_ticks  <= 16'd10;
      active_channels <= 3'd4;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        lds_pkg::REG_RAMP_STEP:    ramp_step       <= cfg_wdata[VW-1:0];
        lds_pkg::REG_INTERVAL:     interval_ticks  <= cfg_wdata;
        lds_pkg::REG_ACTIVE_CHANS: active_channels <= cfg_wdata[lds_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ready3   = !m_tvalid || m_tready;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && s_tready;
  assign adv.adv1 = accept;
  assign adv.adv2 = valid1 && ready2;
  assign adv.adv3 = valid2 && ready3;

  always_comb begin
    step     = (ramp_step == '0) ? 8'd1 : ramp_step;
    tick_inc = (tick_count == '1) ? tick_count : (tick_count + 16'd1);
    fire     = (tick_inc >= interval_ticks);
    bump_sum = {1'b0, bright_target} + {1'b0, in_value};
    level_next  = bright_level;
    target_next = bright_target;
    on_next     = switched_on;
    tick_next   = tick_count;
    if (accept) begin
      unique case (in_op)
        lds_pkg::OP_TICK: begin
          if (switched_on) begin
            if (fire) begin
              level_next = lds_pkg::approach(bright_level, bright_target, step);
              tick_next  = '0;
            end else begin
              tick_next = tick_inc;
            end
          end
        end
        lds_pkg::OP_SET: begin
          target_next = (in_value > lds_pkg::PERCENT_MAX) ? lds_pkg::PERCENT_MAX : in_value;
        end
        lds_pkg::OP_BUMP: begin
          target_next = (bump_sum > {1'b0, lds_pkg::PERCENT_MAX}) ? in_value
                                                                   : bump_sum[VW-1:0];
        end
        lds_pkg::OP_ON: begin
          if (!switched_on) begin
            on_next    = 1'b1;
            level_next = '0;
            tick_next  = '0;
          end
        end
        lds_pkg::OP_OFF: begin
          if (switched_on) begin
            on_next    = 1'b0;
            level_next = bright_target;
          end
        end
        default: ;
      endcase
    end
    lane_ctl.ramp  = accept && (in_op == lds_pkg::OP_TICK) && switched_on && fire;
    lane_ctl.adopt = accept && (in_op == lds_pkg::OP_ON) && !switched_on;
  end

  assign moving_next = on_next && ((level_next != target_next) || (|lane_diff));

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_level  <= '0;
      bright_target <= '0;
      switched_on   <= 1'b0;
      tick_count    <= '0;
    end else begin
      bright_level  <= level_next;
      bright_target <= target_next;
      switched_on   <= on_next;
      tick_count    <= tick_next;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
    logic          driven;
    logic          load;
    logic [VW-1:0] goal_in;
    logic [VW-1:0] now_next;
    logic [VW-1:0] color_in;

    assign driven = (IDX < IDX_W'(active_channels));
    if (i < 4) begin : g_fed
      assign goal_in = in_color[i];
      assign load = accept && (in_op == lds_pkg::OP_LOAD) && ((i < 3) || in_color_count[2]);
    end else begin : g_unfed
      assign goal_in = '0;
      assign load = 1'b0;
    end
    assign color_in = (on_next && driven) ? now_next : '0;

    lds_ramp_lane u_ramp (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lane_ctl),
      .driven   (driven),
      .load     (load),
      .goal_in  (goal_in),
      .step     (step),
      .now_next (now_next),
      .diff     (lane_diff[i])
    );

    lds_duty_lane u_duty (
      .clk      (clk),
      .adv      (adv),
      .color_in (color_in),
      .level1   (level1),
      .duty     (lane_duty[i])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_out
    if (k < CHANNELS) begin : g_live
      assign duty_out[k] = lane_duty[k];
    end else begin : g_none
      assign duty_out[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1   <= 1'b0;
      valid2   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv.adv1) begin
        valid1 <= 1'b1;
      end else if (adv.adv2) begin
        valid1 <= 1'b0;
      end
      if (adv.adv2) begin
        valid2 <= 1'b1;
      end else if (adv.adv3) begin
        valid2 <= 1'b0;
      end
      if (adv.adv3) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      level1  <= level_next;
      on1     <= on_next;
      moving1 <= moving_next;
    end
    if (adv.adv2) begin
      on2     <= on1;
      moving2 <= moving1;
    end
    if (adv.adv3) begin
      lamp_on <= on2;
      ramping <= moving2;
    end
  end

  assign m_tdata = {6'd0, ramping, lamp_on, duty_out[3], duty_out[2], duty_out[1], duty_out[0]};

  a_ramping_needs_on: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (lamp_on || !ramping))
    else $error("ramping reported while the lamp is off");

  a_off_duties_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !lamp_on) |-> (m_tdata[31:0] == 32'd0))
    else $error("non-zero duty while the lamp is off");

  a_tick_holds_off: assert property (@(posedge clk) disable iff (rst)
    !switched_on |=> $stable(tick_count) || switched_on)
    else $error("tick count moved while switched off");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (valid1 && valid2 && m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

@@ design/lds_ramp_lane.sv @@
// One colour channel: current and target colour, the current one ramped toward the target.
`default_nettype none
module lds_ramp_lane (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lds_pkg::lane_ctl_t           ctl,
  input  wire logic                         driven,
  input  wire logic                         load,
  input  wire logic [lds_pkg::VALUE_W-1:0]  goal_in,
  input  wire logic [lds_pkg::VALUE_W-1:0]  step,
  output logic      [lds_pkg::VALUE_W-1:0]  now_next,
  output logic                              diff
);

  logic [lds_pkg::VALUE_W-1:0] color_now;
  logic [lds_pkg::VALUE_W-1:0] color_goal;
  logic [lds_pkg::VALUE_W-1:0] goal_next;

  always_comb begin
    now_next  = color_now;
    goal_next = color_goal;
    if (driven && ctl.ramp) begin
      now_next = lds_pkg::approach(color_now, color_goal, step);
    end
    if (driven && ctl.adopt && (color_now == '0)) begin
      now_next = color_goal;
    end
    if (driven && load) begin
      goal_next = goal_in;
    end
    diff = driven && (now_next != goal_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_now  <= '0;
      color_goal <= '0;
    end else begin
      color_now  <= now_next;
      color_goal <= goal_next;
    end
  end

endmodule
`default_nettype wire

@@ design/lds_duty_lane.sv @@
// One duty channel: level times colour, divided by one hundred and saturated, in three stages.
`default_nettype none
module lds_duty_lane (
  input  wire logic                         clk,
  input  wire lds_pkg::pipe_adv_t           adv,
  input  wire logic [lds_pkg::VALUE_W-1:0]  color_in,
  input  wire logic [lds_pkg::VALUE_W-1:0]  level1,
  output logic      [lds_pkg::VALUE_W-1:0]  duty
);

  localparam int unsigned FULL_W = lds_pkg::PROD_W + lds_pkg::RECIP_W;

  logic [lds_pkg::VALUE_W-1:0] color1;
  logic [lds_pkg::PROD_W-1:0]  prod2;
  logic [FULL_W-1:0]           scaled;
  logic [lds_pkg::QUOT_W-1:0]  quot;
  logic [lds_pkg::VALUE_W-1:0] duty_next;

  always_comb begin
    scaled = FULL_W'(prod2) * FULL_W'(lds_pkg::RECIP_100);
    quot   = scaled[lds_pkg::RECIP_SHIFT +: lds_pkg::QUOT_W];
    duty_next = (quot > lds_pkg::QUOT_W'(lds_pkg::DUTY_MAX)) ? lds_pkg::DUTY_MAX
                                                          : quot[lds_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      color1 <= color_in;
    end
    if (adv.adv2) begin
      prod2 <= lds_pkg::PROD_W'(level1) * lds_pkg::PROD_W'(color1);
    end
    if (adv.adv3) begin
      duty <= duty_next;
    end
  end

endmodule
`default_nettype wire

@@ verif/led_dimmer_slew_ramp_tb.sv @@
// Self-checking testbench of the LED dimmer: directed and random command streams against a built-in predictor.
module led_dimmer_slew_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned STALL_CYCLES = 400;

  typedef struct packed {
    logic [3:0][7:0] duty;
    logic            lamp_on;
    logic            ramping;
  } duty_report_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_addr = lds_pkg::REG_RAMP_STEP;
  logic [15:0] cfg_wdata = '0;

  logic [7:0]  ramp_step = 8'd1;
  logic [15:0] interval_ticks = 16'd10;
  logic [2:0]  active_channels = 3'd4;
  logic [7:0]  pred_level = '0;
  logic [7:0]  pred_level_goal = '0;
  logic [7:0]  colour_now [4] = '{default: '0};
  logic [7:0]  colour_goal [4] = '{default: '0};
  logic        lamp_lit = 1'b0;
  logic [15:0] tick_count = '0;

  logic [47:0]  pending_cmds [$];
  duty_report_t duty_expect [$];
  duty_report_t want;
  string        duty_names [4] = '{"duty_a", "duty_b", "duty_c", "duty_d"};
  int unsigned  send_idle_pct = 18;
  int unsigned  recv_idle_pct = 59;
  int unsigned  items_queued = 0;
  int unsigned  results_seen = 0;
  int unsigned  errors = 0;
  int unsigned  stall_asked = 0;
  int unsigned  stall_served = 0;
  int unsigned  stall_left = 0;
  logic         cmd_taken = 1'b0;

  led_dimmer_slew_ramp dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] slew(input logic [7:0] cur, input logic [7:0] goal,
                                      input int unsigned step);
    int unsigned gap;
    gap = (cur < goal) ? int'(goal) - int'(cur) : int'(cur) - int'(goal);
    if (step < gap)
      gap = step;
    return (cur < goal) ? cur + 8'(gap) : cur - 8'(gap);
  endfunction

  function automatic duty_report_t apply_command(input logic [47:0] word);
    logic [2:0]   op;
    logic [7:0]   val;
    int unsigned  driven;
    int unsigned  loads;
    int unsigned  step;
    int unsigned  sum;
    int unsigned  prod;
    int           ch;
    duty_report_t rep;
    op = word[2:0];
    val = word[10:3];
    driven = (active_channels > 4) ? 4 : active_channels;
    step = (ramp_step == 0) ? 1 : ramp_step;
    case (op)
      lds_pkg::OP_TICK: begin
        if (lamp_lit) begin
          if (tick_count != 16'hFFFF)
            tick_count = tick_count + 16'd1;
          if (tick_count >= interval_ticks) begin
            pred_level = slew(pred_level, pred_level_goal, step);
            for (ch = 0; ch < driven; ch++)
              colour_now[ch] = slew(colour_now[ch], colour_goal[ch], step);
            tick_count = '0;
          end
        end
      end
      lds_pkg::OP_SET: begin
        pred_level_goal = (val > lds_pkg::PERCENT_MAX) ? lds_pkg::PERCENT_MAX : val;
      end
      lds_pkg::OP_BUMP: begin
        sum = int'(pred_level_goal) + int'(val);
        pred_level_goal = (sum > 100) ? val : 8'(sum);
      end
      lds_pkg::OP_ON: begin
        if (!lamp_lit) begin
          lamp_lit = 1'b1;
          pred_level = '0;
          tick_count = '0;
          for (ch = 0; ch < driven; ch++)
            if (colour_now[ch] == 0)
              colour_now[ch] = colour_goal[ch];
        end
      end
      lds_pkg::OP_OFF: begin
        if (lamp_lit) begin
          lamp_lit = 1'b0;
          pred_level = pred_level_goal;
        end
      end
      lds_pkg::OP_LOAD: begin
        loads = (word[45:43] >= 3'd4) ? 4 : 3;
        for (ch = 0; ch < driven && ch < loads; ch++)
          colour_goal[ch] = word[11 + 8 * ch +: 8];
      end
      default: begin
      end
    endcase
    rep.lamp_on = lamp_lit;
    rep.ramping = lamp_lit && (pred_level != pred_level_goal);
    for (ch = 0; ch < 4; ch++) begin
      prod = 0;
      if (lamp_lit && ch < driven) begin
        if (colour_now[ch] != colour_goal[ch])
          rep.ramping = 1'b1;
        prod = int'(pred_level) * int'(colour_now[ch]) / 100;
        if (prod > lds_pkg::DUTY_MAX)
          prod = lds_pkg::DUTY_MAX;
      end
      rep.duty[ch] = 8'(prod);
    end
    return rep;
  endfunction

  task automatic check_field(input string name, input int unsigned expected_val,
                             input int unsigned actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || cmd_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata <= pending_cmds.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_served != stall_asked) begin
      stall_served = stall_asked;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (duty_expect.size() == 0) begin
          $error("result transfer with no command waiting: %h", m_tdata);
          errors++;
        end else begin
          want = duty_expect.pop_front();
          for (int ch = 0; ch < 4; ch++)
            check_field(duty_names[ch], want.duty[ch], m_tdata[8 * ch +: 8]);
          check_field("lamp_on", want.lamp_on, m_tdata[32]);
          check_field("ramping", want.ramping, m_tdata[33]);
        end
      end
      if (s_tvalid && s_tready) begin
        cmd_taken = 1'b1;
        duty_expect.push_back(apply_command(s_tdata));
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [7:0] value,
                           input logic [7:0] ca, input logic [7:0] cb, input logic [7:0] cc,
                           input logic [7:0] cd, input logic [2:0] count);
    pending_cmds.push_back({2'b00, count, cd, cc, cb, ca, value, op});
    items_queued++;
  endtask

  task automatic queue_random_cmd();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  value;
    logic [7:0]  colour [4];
    pick = $urandom_range(0, 99);
    if (pick < 52)
      op = lds_pkg::OP_TICK;
    else if (pick < 60)
      op = lds_pkg::OP_SET;
    else if (pick < 68)
      op = lds_pkg::OP_BUMP;
    else if (pick < 76)
      op = lds_pkg::OP_ON;
    else if (pick < 83)
      op = lds_pkg::OP_OFF;
    else if (pick < 95)
      op = lds_pkg::OP_LOAD;
    else
      op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
    value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 110));
    for (int ch = 0; ch < 4; ch++)
      colour[ch] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    queue_cmd(op, value, colour[0], colour[1], colour[2], colour[3], 3'($urandom_range(0, 7)));
  endtask

  task automatic write_reg(input lds_pkg::reg_index_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      lds_pkg::REG_RAMP_STEP:    ramp_step = data[7:0];
      lds_pkg::REG_INTERVAL:     interval_ticks = data;
      lds_pkg::REG_ACTIVE_CHANS: active_channels = data[2:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (results_seen < items_queued)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] step, input logic [15:0] interval,
                           input logic [2:0] active, input int unsigned count,
                           input int unsigned sender_idle, input int unsigned receiver_idle,
                           input bit hold_receiver);
    write_reg(lds_pkg::REG_RAMP_STEP, {8'($urandom_range(0, 255)), step});
    write_reg(lds_pkg::REG_INTERVAL, interval);
    write_reg(lds_pkg::REG_ACTIVE_CHANS, {13'($urandom_range(0, 8191)), active});
    @(posedge clk);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    if (hold_receiver)
      stall_asked++;
    repeat (count) queue_random_cmd();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    queue_cmd(lds_pkg::OP_LOAD, 8'd0, 8'd255, 8'd0, 8'd128, 8'd1, 3'd4);
    queue_cmd(lds_pkg::OP_SET, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_ON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    repeat (10) queue_cmd(lds_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_BUMP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_BUMP, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_OFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_OFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_ON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(OP_SPARE_LO, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7);
    queue_cmd(OP_SPARE_HI, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_LOAD, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 3'd3);
    queue_cmd(lds_pkg::OP_LOAD, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 3'd0);
    queue_cmd(lds_pkg::OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7);
    queue_cmd(lds_pkg::OP_SET, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_BUMP, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    queue_cmd(lds_pkg::OP_SET, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    wait_drained();

    run_phase(8'd0, 16'd1, 3'd4, 300, 18, 59, 1'b0);
    run_phase(8'd255, 16'd0, 3'd1, 250, 18, 59, 1'b0);
    run_phase(8'd3, 16'd2, 3'd3, 250, 59, 18, 1'b0);
    run_phase(8'd1, 16'd65535, 3'd0, 100, 59, 18, 1'b0);
    run_phase(8'd17, 16'd3, 3'd7, 250, 59, 18, 1'b0);
    run_phase(8'd255, 16'd1, 3'd2, 250, 0, 0, 1'b1);
    run_phase(8'd5, 16'd0, 3'd5, 250, 0, 0, 1'b0);
    run_phase(8'd2, 16'd4, 3'd4, 300, 0, 0, 1'b0);

    if (duty_expect.size() != 0) begin
      $error("%0d expected results never arrived", duty_expect.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
